// ===== hdl/atr_pkg.sv =====
// atr_pkg: shared constants, controller state type and the command/status
// structs that join the controller to the datapath of the average true range tracker.
// No dependencies.
`default_nettype none

package atr_pkg;

    // parameter defaults
    localparam int WINDOW_MAX_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    // fixed field widths and constants
    localparam int FRAC_BITS    = 8;
    localparam int OUT_W        = 40;
    localparam int CFG_W        = 7;
    localparam int WINDOW_RESET = 14;

    // controller states, one-hot
    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RANGE  = 8'b0000_0010,
        S_FILL   = 8'b0000_0100,
        S_START1 = 8'b0000_1000,
        S_WAIT1  = 8'b0001_0000,
        S_START2 = 8'b0010_0000,
        S_WAIT2  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    // divider dividend select
    typedef enum logic {
        DIV_AVG = 1'b0,
        DIV_ATR = 1'b1
    } t_div_sel;

    // controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     calc_range;
        logic     fill;
        logic     div_start;
        t_div_sel div_sel;
        logic     take_avg;
        logic     finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ===== hdl/atr_ram.sv =====
// atr_ram: generic simple dual-port ram, one write port and one registered read port.
// No dependencies.
`default_nettype none

module atr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/atr_div.sv =====
// atr_div: restoring unsigned divider, one quotient bit per cycle.
// No package dependencies.
`default_nettype none

module atr_div #(
    parameter int DIV_W = 46,
    parameter int N_W   = 7
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DIV_W-1:0] i_dividend,
    input  wire logic [N_W-1:0]   i_divisor,
    output logic                  o_done,
    output logic      [DIV_W-1:0] o_quotient,
    output logic      [N_W-1:0]   o_remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [DIV_W-1:0] r_quo;
    logic [N_W-1:0]   r_rem;
    logic [N_W-1:0]   r_dvs;

    logic [N_W:0]     w_trial;
    logic [N_W:0]     w_sub;
    logic             w_ge;
    logic [N_W-1:0]   n_rem;

    // one restoring step: shift in the next dividend bit and try the subtract
    always_comb begin
        w_trial = {r_rem, r_quo[DIV_W-1]};
        w_sub   = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        n_rem   = w_ge ? w_sub[N_W-1:0] : w_trial[N_W-1:0];
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[DIV_W-2:0], w_ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// ===== hdl/atr_ctrl.sv =====
// atr_ctrl: controller state machine of the average true range tracker.
// Depends on atr_pkg.
`default_nettype none

module atr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_stall,
    input  wire atr_pkg::t_status i_status,
    output atr_pkg::t_cmd        o_cmd
);

    import atr_pkg::*;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_RANGE;
                end
            end
            S_RANGE: begin
                o_cmd.calc_range = 1'b1;
                n_state          = i_status.full ? S_START1 : S_FILL;
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                n_state    = S_IDLE;
            end
            S_START1: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_AVG;
                n_state         = S_WAIT1;
            end
            S_WAIT1: begin
                if (i_status.div_done) begin
                    o_cmd.take_avg = 1'b1;
                    n_state        = S_START2;
                end
            end
            S_START2: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ATR;
                n_state         = S_WAIT2;
            end
            S_WAIT2: begin
                if (i_status.div_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/atr_dp.sv =====
// atr_dp: datapath of the average true range tracker: true range, window ring,
// running sum, shared divider and output register. Depends on atr_pkg, atr_ram, atr_div.
`default_nettype none

module atr_dp #(
    parameter int WINDOW_MAX = atr_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = atr_pkg::PRICE_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [atr_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic [PRICE_BITS-1:0]      i_high_price,
    input  wire logic [PRICE_BITS-1:0]      i_low_price,
    input  wire logic [PRICE_BITS-1:0]      i_close_price,
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic      [atr_pkg::OUT_W-1:0]  o_atr_value,
    input  wire atr_pkg::t_cmd              i_cmd,
    output atr_pkg::t_status                o_status
);

    import atr_pkg::*;

    localparam int AW      = $clog2(WINDOW_MAX);
    localparam int N_W     = $clog2(WINDOW_MAX + 1);
    localparam int BS_W    = $clog2(WINDOW_MAX + 2);
    localparam int SUM_W   = PRICE_BITS + $clog2(WINDOW_MAX);
    localparam int ACC_W   = PRICE_BITS + FRAC_BITS;
    localparam int DIV_W   = SUM_W + FRAC_BITS;
    localparam int N_RESET = (WINDOW_MAX < WINDOW_RESET) ? WINDOW_MAX : WINDOW_RESET;

    // state registers
    logic [N_W-1:0]        r_n;
    logic [BS_W-1:0]       r_bars;
    logic [SUM_W-1:0]      r_sum;
    logic [AW-1:0]         r_oldest;
    logic [PRICE_BITS-1:0] r_prev_close;
    logic                  r_out_valid;

    // payload registers
    logic [PRICE_BITS-1:0] r_high;
    logic [PRICE_BITS-1:0] r_low;
    logic [PRICE_BITS-1:0] r_close;
    logic [PRICE_BITS-1:0] r_tr;
    logic [ACC_W-1:0]      r_avg;
    logic                  r_up;
    logic [ACC_W-1:0]      r_atr;

    logic [N_W-1:0]        w_cfg_n;
    logic [PRICE_BITS-1:0] w_hl;
    logic [PRICE_BITS-1:0] w_hc;
    logic [PRICE_BITS-1:0] w_lc;
    logic [PRICE_BITS-1:0] w_tr;
    logic [ACC_W-1:0]      w_t;
    logic                  w_up;
    logic [ACC_W-1:0]      w_diff;
    logic [DIV_W-1:0]      w_dividend;
    logic                  w_div_done;
    logic [DIV_W-1:0]      w_quo;
    logic [N_W-1:0]        w_rem;
    logic [ACC_W-1:0]      w_q;
    logic [ACC_W-1:0]      w_atr;
    logic [N_W:0]          w_next_slot;
    logic                  w_ram_we;
    logic [AW-1:0]         w_ram_waddr;
    logic [PRICE_BITS-1:0] w_ram_rd;

    // clamp the written window length to 1..WINDOW_MAX
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            w_cfg_n = N_W'(1);
        end else if (32'(i_cfg_wr_data) > 32'(WINDOW_MAX)) begin
            w_cfg_n = N_W'(WINDOW_MAX);
        end else begin
            w_cfg_n = N_W'(i_cfg_wr_data);
        end
    end

    // true range from the latched bar and the previous close
    always_comb begin
        w_hl = (r_high >= r_low) ? (r_high - r_low) : '0;
        w_hc = (r_high >= r_prev_close) ? (r_high - r_prev_close) : (r_prev_close - r_high);
        w_lc = (r_low >= r_prev_close) ? (r_low - r_prev_close) : (r_prev_close - r_low);
        w_tr = w_hl;
        if (w_hc > w_tr) begin
            w_tr = w_hc;
        end
        if (w_lc > w_tr) begin
            w_tr = w_lc;
        end
    end

    // divider operands: scaled sum, or distance of the new range from the average
    always_comb begin
        w_t    = {r_tr, FRAC_BITS'(0)};
        w_up   = (w_t >= r_avg);
        w_diff = w_up ? (w_t - r_avg) : (r_avg - w_t);
        if (i_cmd.div_sel == DIV_AVG) begin
            w_dividend = {r_sum, FRAC_BITS'(0)};
        end else begin
            w_dividend = DIV_W'(w_diff);
        end
    end

    // result: step toward the new range, rounding the downward step up
    always_comb begin
        w_q = w_quo[ACC_W-1:0];
        if (r_up) begin
            w_atr = r_avg + w_q;
        end else begin
            w_atr = r_avg - w_q - ACC_W'(w_rem != '0);
        end
        w_next_slot = {1'b0, N_W'(r_oldest)} + 1'b1;
    end

    // ring write port: fill slot during warm-up, oldest slot afterwards
    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = r_oldest;
        if (i_cmd.fill && (r_bars != '0)) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = AW'(r_bars - 1'b1);
        end else if (i_cmd.finish) begin
            w_ram_we = 1'b1;
        end
    end

    atr_ram #(
        .WIDTH (PRICE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (r_tr),
        .i_rd_addr (r_oldest),
        .o_rd_data (w_ram_rd)
    );

    atr_div #(
        .DIV_W (DIV_W),
        .N_W   (N_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_cmd.div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (r_n),
        .o_done      (w_div_done),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    // window length, warm-up count, running sum and ring pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n          <= N_W'(N_RESET);
            r_bars       <= '0;
            r_sum        <= '0;
            r_oldest     <= '0;
            r_prev_close <= '0;
        end else if (i_cfg_wr_en) begin
            r_n      <= w_cfg_n;
            r_bars   <= '0;
            r_sum    <= '0;
            r_oldest <= '0;
        end else begin
            if (i_cmd.calc_range) begin
                r_prev_close <= r_close;
            end
            if (i_cmd.fill) begin
                r_bars <= r_bars + 1'b1;
                if (r_bars != '0) begin
                    r_sum <= r_sum + SUM_W'(r_tr);
                end
            end
            if (i_cmd.finish) begin
                r_sum    <= r_sum - SUM_W'(w_ram_rd) + SUM_W'(r_tr);
                r_oldest <= (w_next_slot >= {1'b0, r_n}) ? '0 : AW'(w_next_slot);
            end
        end
    end

    // bar, range and average registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_high  <= i_high_price;
            r_low   <= i_low_price;
            r_close <= i_close_price;
        end
        if (i_cmd.calc_range) begin
            r_tr <= w_tr;
        end
        if (i_cmd.take_avg) begin
            r_avg <= w_quo[ACC_W-1:0];
        end
        if (i_cmd.div_start && (i_cmd.div_sel == DIV_ATR)) begin
            r_up <= w_up;
        end
        if (i_cmd.finish) begin
            r_atr <= w_atr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_atr_value       = OUT_W'(r_atr);
    assign o_status.full     = (r_bars > BS_W'(r_n));
    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// ===== hdl/average_true_range_tracker.sv =====
// average_true_range_tracker: top level, depends on atr_pkg, atr_ctrl and atr_dp.
// Takes one price bar per request (high, low, close) and forms its true range. The first
// bar after reset or after a window_length write only records its close; the next n bars
// fill the window ring and give no result; every later bar gives one ATR result with 8
// fraction bits, computed from the window average and then the new range, after which the
// range replaces the oldest ring entry. A bar that gives a result goes through the range
// step, two passes through the one-bit-per-cycle divider (DIV_W being PRICE_BITS +
// clog2(WINDOW_MAX) + 8) and the finish step, which waits while an earlier result is stalled; a
// warm-up bar goes through the range and fill steps. One bar is worked on at a time; a
// finished result waits in the output register while the next bar is taken. Writing
// window_length (clamped to 1..WINDOW_MAX) restarts the warm-up and keeps the previous close.
`default_nettype none

module average_true_range_tracker #(
    parameter int WINDOW_MAX = atr_pkg::WINDOW_MAX_DEF,
    parameter int PRICE_BITS = atr_pkg::PRICE_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [atr_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic [PRICE_BITS-1:0]     i_high_price,
    input  wire logic [PRICE_BITS-1:0]     i_low_price,
    input  wire logic [PRICE_BITS-1:0]     i_close_price,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic      [atr_pkg::OUT_W-1:0] o_atr_value
);

    import atr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // controller
    atr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // datapath
    atr_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .PRICE_BITS (PRICE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_high_price  (i_high_price),
        .i_low_price   (i_low_price),
        .i_close_price (i_close_price),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_atr_value   (o_atr_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status)
    );

    // an accepted request blocks the input until its work is done
    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not blocked after request");

    // a result only appears from the finish step
    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.finish))
        else $error("output valid without finish");

    // finish never overwrites a stalled result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.finish |-> !(o_out_valid && i_out_stall))
        else $error("result overwritten");

    // the divider is never started in the same cycle in which it signals done
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.div_start |-> !w_status.div_done)
        else $error("divider started while finishing");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for average_true_range_tracker, with bursty bar requests,
// patterned output stalls and a bit-accurate ATR predictor; depends on atr_pkg and the rtl

module testbench;
    import atr_pkg::*;

    localparam int     PRICE_W     = PRICE_BITS_DEF;
    localparam int     WIN_MAX     = WINDOW_MAX_DEF;
    localparam int     DIV_W       = PRICE_W + $clog2(WIN_MAX) + FRAC_BITS;
    localparam int     RESULT_LAT  = 2 * DIV_W + 6;
    localparam int     SETTLE      = RESULT_LAT + 32;
    localparam int     HOLD_LEN    = 900;
    localparam int     TARGET_BARS = 1300;
    localparam longint CYCLE_LIMIT = 1_000_000;
    localparam int     MAX_REPORTS = 10;

    // receiver stall patterns
    typedef enum int {
        RX_FLOW,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    typedef struct packed {
        logic [PRICE_W-1:0] high;
        logic [PRICE_W-1:0] low;
        logic [PRICE_W-1:0] close;
    } t_bar;

    // block ports
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wr_data = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic [PRICE_W-1:0] i_high_price  = '0;
    logic [PRICE_W-1:0] i_low_price   = '0;
    logic [PRICE_W-1:0] i_close_price = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b0;
    logic [OUT_W-1:0]   o_atr_value;

    // predictor state
    logic [CFG_W-1:0]   win_setting  = CFG_W'(WINDOW_RESET);
    logic [PRICE_W-1:0] last_close   = '0;
    int                 warmup_count = 0;
    logic [63:0]        tr_ring[WIN_MAX];
    logic [63:0]        tr_sum       = '0;
    int                 ring_head    = 0;
    logic [OUT_W-1:0]   atr_expected[$];

    // bookkeeping
    int          mismatches      = 0;
    int          results_checked = 0;
    int          bars_sent       = 0;
    int          windows_written = 0;
    int          holds_asked     = 0;
    int          holds_started   = 0;
    int          hold_left       = 0;
    int          mode_left       = 0;
    t_rx_mode    rx_mode         = RX_FLOW;
    int          burst_left      = 0;
    bit          gaps_on         = 1'b1;
    longint      cycle_count     = 0;
    logic [OUT_W-1:0]   atr_want;
    logic [PRICE_W-1:0] walk_level = '0;

    always #5 i_clk = ~i_clk;

    average_true_range_tracker #(
        .WINDOW_MAX(WIN_MAX),
        .PRICE_BITS(PRICE_W)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_high_price  (i_high_price),
        .i_low_price   (i_low_price),
        .i_close_price (i_close_price),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_atr_value   (o_atr_value)
    );

    // window length as the block uses it
    function automatic int clamp_window(int v);
        if (v < 1) return 1;
        if (v > WIN_MAX) return WIN_MAX;
        return v;
    endfunction

    function automatic logic [63:0] bar_true_range(t_bar b);
        logic [63:0] hi, lo, pc, r, dh, dl;
        hi = b.high;
        lo = b.low;
        pc = last_close;
        r  = (hi >= lo) ? hi - lo : 64'd0;
        dh = (hi >= pc) ? hi - pc : pc - hi;
        dl = (lo >= pc) ? lo - pc : pc - lo;
        if (dh > r) r = dh;
        if (dl > r) r = dl;
        return r;
    endfunction

    // window write restarts warm-up, previous close survives
    function automatic void restart_window(logic [CFG_W-1:0] v);
        win_setting  = v;
        warmup_count = 0;
        tr_sum       = '0;
        ring_head    = 0;
    endfunction

    // advance the predicted state by one accepted bar, queue the atr it yields
    function automatic void predict_bar(t_bar b);
        logic [63:0] tr, scaled, avg, atr, nw;
        int n, slot;
        n  = clamp_window(win_setting);
        nw = n;
        tr = bar_true_range(b);
        if (warmup_count >= n + 1) begin
            scaled = tr << FRAC_BITS;
            avg    = (tr_sum / nw) * 256 + ((tr_sum % nw) * 256) / nw;
            if (scaled >= avg) begin
                atr = avg + (scaled - avg) / nw;
            end else begin
                atr = avg - ((avg - scaled) + nw - 1) / nw;
            end
            atr_expected.insert(atr_expected.size(), atr[OUT_W-1:0]);
            slot          = ring_head % n;
            tr_sum        = tr_sum - tr_ring[slot] + tr;
            tr_ring[slot] = tr;
            slot++;
            ring_head     = (slot >= n) ? 0 : slot;
        end else begin
            // first bar only records its close, the next n fill the ring
            if (warmup_count >= 1) begin
                tr_ring[warmup_count - 1] = tr;
                tr_sum += tr;
            end
            warmup_count++;
            if (warmup_count >= n + 1) ring_head = 0;
        end
        last_close = b.close;
    endfunction

    // mostly a drifting market, some fully random and some extreme bars
    function automatic t_bar random_bar();
        t_bar               b;
        logic [PRICE_W-1:0] spread, step, tmp;
        int                 pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            b.high  = $urandom;
            b.low   = $urandom;
            b.close = $urandom;
        end else if (pick < 25) begin
            b.high  = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
            b.low   = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
            b.close = ($urandom_range(0, 2) == 0) ? '0 : ($urandom_range(0, 1) ? '1 : $urandom);
        end else begin
            if ($urandom_range(0, 31) == 0) walk_level = $urandom;
            spread     = $urandom & ((32'd1 << $urandom_range(0, 16)) - 1);
            step       = $urandom & ((32'd1 << $urandom_range(0, 12)) - 1);
            walk_level = $urandom_range(0, 1) ? walk_level + step : walk_level - step;
            b.high     = walk_level + spread;
            b.low      = walk_level - (spread >> $urandom_range(0, 4));
            b.close    = b.low + ((spread == 0) ? '0 : PRICE_W'($urandom % spread));
            // now and then an inverted bar
            if ($urandom_range(0, 19) == 0) begin
                tmp    = b.high;
                b.high = b.low;
                b.low  = tmp;
            end
        end
        return b;
    endfunction

    // send one bar request, with bursts and gaps when enabled
    task automatic send_bar(input t_bar b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 20);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid    <= 1'b1;
        i_high_price  <= b.high;
        i_low_price   <= b.low;
        i_close_price <= b.close;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_bar(b);
        bars_sent++;
    endtask

    // stop sending and wait for every expected atr
    task automatic wait_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (atr_expected.size() != 0) @(posedge i_clk);
    endtask

    // window write only on an idle block
    task automatic write_window(input logic [CFG_W-1:0] v);
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        restart_window(v);
        i_cfg_wr_en <= 1'b0;
        windows_written++;
    endtask

    // reset window of 14, warm-up then a few results
    task automatic test_reset_window();
        send_bar(t_bar'{{PRICE_W{1'b1}}, {PRICE_W{1'b0}}, {PRICE_W{1'b1}}});
        repeat (16) send_bar(random_bar());
    endtask

    // price extremes and the true range corner cases on short windows
    task automatic test_price_extremes();
        write_window(CFG_W'(1));
        send_bar(t_bar'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_bar(t_bar'{32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff});
        send_bar(t_bar'{32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000});
        // low above high
        send_bar(t_bar'{32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff});
        send_bar(t_bar'{32'h0000_0005, 32'h0000_000a, 32'h0000_0007});
        write_window(CFG_W'(2));
        send_bar(t_bar'{32'h0000_0064, 32'h0000_0032, 32'h0000_004b});
        // high minus low dominates
        send_bar(t_bar'{32'h0000_0050, 32'h0000_003c, 32'h0000_00c8});
        // low below previous close dominates
        send_bar(t_bar'{32'h0000_0096, 32'h0000_0078, 32'h0000_0082});
        send_bar(t_bar'{32'h8000_0000, 32'h7fff_ffff, 32'h5555_5555});
        send_bar(t_bar'{32'haaaa_aaaa, 32'h5555_5555, 32'hffff_ffff});
        send_bar(t_bar'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
        send_bar(t_bar'{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    endtask

    // out-of-range window values clamp to 1 and to the maximum
    task automatic test_window_clamp();
        write_window(CFG_W'(0));
        repeat (6) send_bar(random_bar());
        write_window({CFG_W{1'b1}});
        repeat (WIN_MAX + 5) send_bar(random_bar());
        write_window(CFG_W'(WIN_MAX + 1));
        repeat (WIN_MAX + 3) send_bar(random_bar());
        write_window(CFG_W'(WIN_MAX));
        repeat (WIN_MAX + 4) send_bar(random_bar());
    endtask

    // restart during warm-up and during steady running
    task automatic test_restart();
        write_window(CFG_W'(5));
        repeat (3) send_bar(random_bar());
        write_window(CFG_W'(3));
        repeat (8) send_bar(random_bar());
        write_window(CFG_W'(2));
        repeat (6) send_bar(random_bar());
    endtask

    // long output hold while requests keep coming, so the input stalls
    task automatic test_output_hold();
        write_window(CFG_W'(2));
        gaps_on = 1'b0;
        repeat (3) send_bar(random_bar());
        holds_asked++;
        repeat (14) send_bar(random_bar());
        gaps_on = 1'b1;
        wait_results();
    endtask

    // sender pauses until every result is back
    task automatic test_source_pause();
        write_window(CFG_W'(4));
        repeat (4) begin
            repeat ($urandom_range(3, 8)) send_bar(random_bar());
            wait_results();
        end
    endtask

    // random phases of window settings and bars until the bar budget is spent
    task automatic test_random_bars();
        int setting, n, count;
        while (bars_sent < TARGET_BARS) begin
            case ($urandom_range(0, 9))
                0:       setting = $urandom_range(0, (1 << CFG_W) - 1);
                1, 2:    setting = $urandom_range(17, WIN_MAX);
                default: setting = $urandom_range(1, 16);
            endcase
            n = clamp_window(setting);
            if ($urandom_range(0, 9) == 0) begin
                count = $urandom_range(1, n);
            end else begin
                count = n + 1 + $urandom_range(4, 40);
            end
            gaps_on = ($urandom_range(0, 3) != 0);
            write_window(CFG_W'(setting));
            repeat (count) send_bar(random_bar());
        end
        gaps_on = 1'b1;
    endtask

    // receiver stall pattern, with long holds on request
    always @(posedge i_clk) begin
        if (hold_left == 0 && holds_started != holds_asked) begin
            holds_started++;
            hold_left = HOLD_LEN;
        end
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (rx_mode)
                RX_FLOW:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:  i_out_stall <= ((mode_left % 7) < 3);
            endcase
        end
    end

    // compare each accepted atr with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (atr_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected atr_value %h", $time, o_atr_value);
                end
            end else begin
                atr_want = atr_expected.pop_front();
                results_checked++;
                if (o_atr_value !== atr_want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] atr_value mismatch: expected %h, got %h",
                                 $time, atr_want, o_atr_value);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, atr_expected.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_window();
        test_price_extremes();
        test_window_clamp();
        test_restart();
        test_output_hold();
        test_source_pause();
        test_random_bars();
        wait_results();
        repeat (SETTLE) @(posedge i_clk);
        if (atr_expected.size() != 0) begin
            $display("%0d expected atr results never arrived", atr_expected.size());
            mismatches += atr_expected.size();
        end
        $display("run covered %0d bars, %0d atr results checked, %0d window writes,",
                 bars_sent, results_checked, windows_written);
        $display("%0d long output holds and %0d mismatches in %0d cycles",
                 holds_started, mismatches, cycle_count);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
